@@ rtl/weighted_index_sampler_macros.svh @@
// Assertion macros shared by the sampler modules.
`ifndef WEIGHTED_INDEX_SAMPLER_MACROS_SVH
`define WEIGHTED_INDEX_SAMPLER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define WIS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define WIS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/wis_pkg.sv @@
`timescale 1ns / 1ps

package wis_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int WEIGHT_BITS = 40;
    localparam int LABEL_BITS  = 20;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 2);
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENTRY_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TOTAL_WEIGHT = 2'd1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef struct packed {
        logic start;
        logic write_entry;
        logic issue;
        logic compare;
        logic label_rd;
        logic out_load;
    } wis_cmd_t;

    typedef struct packed {
        logic search_done;
        logic oor_now;
    } wis_stat_t;

endpackage

@@ rtl/wis_ram.sv @@
`timescale 1ns / 1ps

module wis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/wis_datapath.sv @@
`timescale 1ns / 1ps
`include "weighted_index_sampler_macros.svh"

module wis_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wis_pkg::wis_cmd_t                    cmd,
    output wis_pkg::wis_stat_t                   stat,
    input  logic                                 cfg_we,
    input  logic [wis_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      cfg_data,
    input  logic [wis_pkg::ADDR_BITS-1:0]        entry_position,
    input  logic [wis_pkg::LABEL_BITS-1:0]       entry_label,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      start_weight,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      random_value,
    output logic [wis_pkg::LABEL_BITS-1:0]       chosen_label,
    output logic [wis_pkg::ADDR_BITS-1:0]        chosen_position,
    output logic                                 out_of_range
);

    import wis_pkg::*;

    logic [COUNT_BITS-1:0]  entry_count_reg;
    logic [WEIGHT_BITS-1:0] total_weight_reg;

    logic [COUNT_BITS-1:0]  cnt_used;
    logic [WEIGHT_BITS-1:0] v_reg;
    logic [COUNT_BITS-1:0]  lo_reg, lo_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [COUNT_BITS-1:0]  half;
    logic [COUNT_BITS-1:0]  mid_reg, mid_next;
    logic                   bound_reg;
    logic                   oor_reg;
    logic [ADDR_BITS-1:0]   q_reg, q_next;
    logic [WEIGHT_BITS-1:0] w_rdata;
    logic [WEIGHT_BITS-1:0] w_sel;
    logic [LABEL_BITS-1:0]  l_rdata;
    logic [ADDR_BITS-1:0]   w_addr, l_addr;

    logic [LABEL_BITS-1:0]  chosen_label_reg;
    logic [ADDR_BITS-1:0]   chosen_position_reg;
    logic                   out_of_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg  <= COUNT_BITS'(1);
            total_weight_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENTRY_COUNT:  entry_count_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_TOTAL_WEIGHT: total_weight_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (entry_count_reg == '0)
            cnt_used = COUNT_BITS'(1);
        else if (entry_count_reg > COUNT_BITS'(TABLE_DEPTH))
            cnt_used = COUNT_BITS'(TABLE_DEPTH);
        else
            cnt_used = entry_count_reg;
    end

    assign half     = n_reg >> 1;
    assign mid_next = lo_reg + half;
    assign w_sel    = bound_reg ? total_weight_reg : w_rdata;

    always_comb
    begin
        lo_next = lo_reg;
        n_next  = half;
        if (w_sel < v_reg)
        begin
            lo_next = mid_reg + COUNT_BITS'(1);
            n_next  = n_reg - half - COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        if (lo_reg == '0)
            q_next = '0;
        else
            q_next = ADDR_BITS'(lo_reg - COUNT_BITS'(1));
    end

    assign stat.search_done = (n_reg == '0);
    assign stat.oor_now     = (random_value > total_weight_reg);

    assign w_addr = cmd.write_entry ? entry_position : mid_next[ADDR_BITS-1:0];
    assign l_addr = cmd.write_entry ? entry_position : q_next;

    wis_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (cmd.write_entry),
        .re    (cmd.issue),
        .addr  (w_addr),
        .wdata (start_weight),
        .rdata (w_rdata)
    );

    wis_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_label_ram (
        .clk   (clk),
        .we    (cmd.write_entry),
        .re    (cmd.label_rd),
        .addr  (l_addr),
        .wdata (entry_label),
        .rdata (l_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            v_reg   <= random_value;
            oor_reg <= stat.oor_now;
            lo_reg  <= '0;
            n_reg   <= cnt_used + COUNT_BITS'(1);
        end
        if (cmd.issue)
        begin
            mid_reg   <= mid_next;
            bound_reg <= (mid_next >= cnt_used);
        end
        if (cmd.compare)
        begin
            lo_reg <= lo_next;
            n_reg  <= n_next;
        end
        if (cmd.label_rd)
        begin
            q_reg <= q_next;
        end
        if (cmd.out_load)
        begin
            chosen_label_reg    <= oor_reg ? '0 : l_rdata;
            chosen_position_reg <= oor_reg ? '0 : q_reg;
            out_of_range_reg    <= oor_reg;
        end
    end

    assign chosen_label    = chosen_label_reg;
    assign chosen_position = chosen_position_reg;
    assign out_of_range    = out_of_range_reg;

    `WIS_ASSERT_SAME(a_compare_live, clk, rst_n, cmd.compare, n_reg != '0, "compare with empty range")
    `WIS_ASSERT_SAME(a_lo_in_bound, clk, rst_n, cmd.issue || cmd.label_rd, lo_reg <= cnt_used, "search passed bound")
    `WIS_ASSERT_NEXT(a_start_clears, clk, rst_n, cmd.start, lo_reg == '0, "search start lost")

endmodule

@@ rtl/wis_ctrl.sv @@
`timescale 1ns / 1ps
`include "weighted_index_sampler_macros.svh"

module wis_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               kind,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  wis_pkg::wis_stat_t stat,
    output wis_pkg::wis_cmd_t  cmd
);

    import wis_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_ISSUE   = 4'b0010,
        ST_COMPARE = 4'b0100,
        ST_DONE    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_DRAW)
                    begin
                        cmd.start  = 1'b1;
                        state_next = stat.oor_now ? ST_DONE : ST_ISSUE;
                    end
                    else
                    begin
                        cmd.write_entry = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (stat.search_done)
                begin
                    cmd.label_rd = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_ISSUE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `WIS_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg, "result transfer lost")
    `WIS_ASSERT_NEXT(a_draw_busy, clk, rst_n, cmd.start, state_reg != ST_IDLE, "draw not started")
    `WIS_ASSERT_SAME(a_held_result, clk, rst_n, out_valid_reg && out_stall, !cmd.out_load, "result overwritten")

endmodule

@@ rtl/weighted_index_sampler.sv @@
`timescale 1ns / 1ps

// Weighted index sampler. Load items (kind 0) write one table entry (running lower cumulative
// weight and label) in the cycle of their transfer and give no result. Draw items (kind 1) run
// a binary lower-bound search over entry_count positions plus the total_weight bound, step
// back one position and return that entry's label and position, or flag out_of_range with
// zero fields when random_value exceeds total_weight. Each search step is one weight memory
// read and one compare, with the entry count clamped to 1..1024; an out-of-range draw skips
// the search. One item is in work at a time; a finished result waits in the output register.
// Entries must be written before a draw can reach them. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
module weighted_index_sampler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [wis_pkg::ADDR_BITS-1:0]        entry_position,
    input  logic [wis_pkg::LABEL_BITS-1:0]       entry_label,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      start_weight,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      random_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wis_pkg::LABEL_BITS-1:0]       chosen_label,
    output logic [wis_pkg::ADDR_BITS-1:0]        chosen_position,
    output logic                                 out_of_range,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wis_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [wis_pkg::WEIGHT_BITS-1:0]      cfg_data
);

    import wis_pkg::*;

    wis_cmd_t  cmd;
    wis_stat_t stat;

    assign cfg_ready = 1'b1;

    wis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    wis_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .entry_position  (entry_position),
        .entry_label     (entry_label),
        .start_weight    (start_weight),
        .random_value    (random_value),
        .chosen_label    (chosen_label),
        .chosen_position (chosen_position),
        .out_of_range    (out_of_range)
    );

endmodule

@@ tb/sv/weighted_index_sampler_test.sv @@
`timescale 1ns / 1ps

module weighted_index_sampler_test;

    import wis_pkg::*;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
    localparam int ITEM_TARGET   = 1950;
    localparam int MAX_WAIT      = 14;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 600000;

    typedef struct packed {
        logic                   kind;
        logic [ADDR_BITS-1:0]   entry_position;
        logic [LABEL_BITS-1:0]  entry_label;
        logic [WEIGHT_BITS-1:0] start_weight;
        logic [WEIGHT_BITS-1:0] random_value;
    } sampler_item_t;

    typedef struct packed {
        logic [LABEL_BITS-1:0] label;
        logic [ADDR_BITS-1:0]  position;
        logic                  oor;
    } pick_t;

    class sampler_scoreboard;
        logic [WEIGHT_BITS-1:0] weight_mem [TABLE_DEPTH];
        logic [LABEL_BITS-1:0]  label_mem [TABLE_DEPTH];
        logic [COUNT_BITS-1:0]  count_reg;
        logic [WEIGHT_BITS-1:0] total_reg;
        pick_t                  expected_picks [$];
        int                     errors;
        int                     loads;
        int                     draws;
        int                     misses;

        function new();
            count_reg = 1;
            total_reg = '0;
            errors = 0;
            loads = 0;
            draws = 0;
            misses = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                     logic [WEIGHT_BITS-1:0] data);
            if (idx == CFG_ENTRY_COUNT)
                count_reg = data[COUNT_BITS-1:0];
            else if (idx == CFG_TOTAL_WEIGHT)
                total_reg = data;
        endfunction

        function pick_t search_pick(logic [WEIGHT_BITS-1:0] v);
            int span;
            int lo;
            int n;
            int half;
            int mid;
            int q;
            logic [WEIGHT_BITS-1:0] w;
            pick_t p;
            p = '0;
            if (v > total_reg)
            begin
                p.oor = 1'b1;
                return p;
            end
            if (count_reg == 0)
                span = 1;
            else if (count_reg > TABLE_DEPTH)
                span = TABLE_DEPTH;
            else
                span = int'(count_reg);
            lo = 0;
            n = span + 1;
            while (n > 0)
            begin
                half = n / 2;
                mid = lo + half;
                w = (mid >= span) ? total_reg : weight_mem[mid];
                if (w < v)
                begin
                    lo = mid + 1;
                    n = n - half - 1;
                end
                else
                begin
                    n = half;
                end
            end
            if (lo > span)
                lo = span;
            q = (lo == 0) ? 0 : lo - 1;
            if (q >= TABLE_DEPTH)
                q = TABLE_DEPTH - 1;
            p.label = label_mem[q];
            p.position = ADDR_BITS'(q);
            return p;
        endfunction

        function void note_transfer(sampler_item_t it);
            pick_t p;
            if (it.kind == KIND_LOAD)
            begin
                weight_mem[it.entry_position] = it.start_weight;
                label_mem[it.entry_position] = it.entry_label;
                loads++;
            end
            else
            begin
                p = search_pick(it.random_value);
                expected_picks.push_back(p);
                draws++;
                if (p.oor)
                    misses++;
            end
        endfunction

        function void check_pick(pick_t got);
            pick_t want;
            if (expected_picks.size() == 0)
            begin
                $error("result transfer with nothing expected: label %0h position %0d",
                       got.label, got.position);
                errors++;
                return;
            end
            want = expected_picks.pop_front();
            if (got.label !== want.label)
            begin
                $error("chosen_label: expected %0h, got %0h", want.label, got.label);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $error("chosen_position: expected %0d, got %0d", want.position, got.position);
                errors++;
            end
            if (got.oor !== want.oor)
            begin
                $error("out_of_range: expected %0b, got %0b", want.oor, got.oor);
                errors++;
            end
        endfunction

        function int pending();
            return expected_picks.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      kind = KIND_LOAD;
    logic [ADDR_BITS-1:0]      entry_position = '0;
    logic [LABEL_BITS-1:0]     entry_label = '0;
    logic [WEIGHT_BITS-1:0]    start_weight = '0;
    logic [WEIGHT_BITS-1:0]    random_value = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [LABEL_BITS-1:0]     chosen_label;
    logic [ADDR_BITS-1:0]      chosen_position;
    logic                      out_of_range;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_ENTRY_COUNT;
    logic [WEIGHT_BITS-1:0]    cfg_data = '0;

    sampler_scoreboard board = new();
    logic [WEIGHT_BITS-1:0] shadow_w [TABLE_DEPTH];
    bit  no_idle = 1'b0;
    bit  long_hold_req = 1'b0;
    int  items_sent = 0;
    int  settings = 0;
    int  cycle_count = 0;

    weighted_index_sampler u_top (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, board.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int n;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else
            begin
                n = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            board.check_pick(pick_t'({chosen_label, chosen_position, out_of_range}));
        end
    end

    function automatic logic [WEIGHT_BITS-1:0] rand_weight();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] rand_total();
        case ($urandom_range(0, 5))
            0: return WEIGHT_MAX;
            1: return '0;
            2: return WEIGHT_BITS'($urandom_range(1, 1000));
            default: return rand_weight();
        endcase
    endfunction

    function automatic int clamp_count(int c);
        if (c == 0)
            return 1;
        if (c > TABLE_DEPTH)
            return TABLE_DEPTH;
        return c;
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] draw_value(int used,
                                                          logic [WEIGHT_BITS-1:0] total);
        logic [63:0] r;
        logic [WEIGHT_BITS-1:0] w;
        r = {$urandom, $urandom};
        w = shadow_w[$urandom_range(0, used - 1)];
        case ($urandom_range(0, 9))
            0: return '0;
            1: return total;
            2: return (total == WEIGHT_MAX) ? total : total + 1'b1;
            3: return rand_weight();
            4: return w;
            5: return w + 1'b1;
            6: return w - 1'b1;
            default: return WEIGHT_BITS'(r % ({24'b0, total} + 64'd1));
        endcase
    endfunction

    task automatic send_item(sampler_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind <= it.kind;
        entry_position <= it.entry_position;
        entry_label <= it.entry_label;
        start_weight <= it.start_weight;
        random_value <= it.random_value;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_transfer(it);
        items_sent++;
    endtask

    task automatic send_load(logic [ADDR_BITS-1:0] pos, logic [LABEL_BITS-1:0] label,
                             logic [WEIGHT_BITS-1:0] w);
        sampler_item_t it;
        it.kind = KIND_LOAD;
        it.entry_position = pos;
        it.entry_label = label;
        it.start_weight = w;
        it.random_value = rand_weight();
        shadow_w[pos] = w;
        send_item(it);
    endtask

    task automatic send_draw(logic [WEIGHT_BITS-1:0] v);
        sampler_item_t it;
        it.kind = KIND_DRAW;
        it.entry_position = ADDR_BITS'($urandom);
        it.entry_label = LABEL_BITS'($urandom);
        it.start_weight = rand_weight();
        it.random_value = v;
        send_item(it);
    endtask

    // running weights rise by random steps so the last one never passes total
    task automatic load_sorted(int n, logic [WEIGHT_BITS-1:0] total);
        logic [63:0] step;
        logic [63:0] w;
        step = {24'b0, total} / n;
        w = '0;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0 && step != 0)
                w += {$urandom, $urandom} % (step + 64'd1);
            send_load(ADDR_BITS'(i), LABEL_BITS'($urandom), w[WEIGHT_BITS-1:0]);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WEIGHT_BITS-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        board.write_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_table(int count, logic [WEIGHT_BITS-1:0] total);
        settle();
        write_reg(CFG_ENTRY_COUNT, WEIGHT_BITS'(count));
        write_reg(CFG_TOTAL_WEIGHT, total);
        settings++;
    endtask

    task automatic mixed_item(int used, logic [WEIGHT_BITS-1:0] total);
        int pos;
        case ($urandom_range(0, 9))
            0: send_load(ADDR_BITS'($urandom), LABEL_BITS'($urandom), rand_weight());
            1:
            begin
                pos = $urandom_range(0, used - 1);
                send_load(ADDR_BITS'(pos), LABEL_BITS'($urandom), shadow_w[pos]);
            end
            default: send_draw(draw_value(used, total));
        endcase
    endtask

    initial
    begin
        int count;
        int used;
        int phase;
        logic [WEIGHT_BITS-1:0] total;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_load('0, '1, '0);
        send_draw('0);
        send_draw(40'd1);
        send_draw(WEIGHT_MAX);

        set_table(4, WEIGHT_MAX);
        send_load(10'd0, 20'h00000, 40'd0);
        send_load(10'd1, 20'h12345, 40'd100);
        send_load(10'd2, 20'hABCDE, 40'd100);
        send_load(10'd3, 20'h55555, 40'h80_0000_0000);
        send_draw(40'd0);
        send_draw(40'd1);
        send_draw(40'd100);
        send_draw(40'd101);
        send_draw(40'h80_0000_0000);
        send_draw(40'h80_0000_0001);
        send_draw(WEIGHT_MAX);

        set_table(2, 40'h80_0000_0000);
        send_draw(WEIGHT_MAX);
        send_draw(40'h80_0000_0000);

        set_table(TABLE_DEPTH, WEIGHT_MAX);
        load_sorted(TABLE_DEPTH, WEIGHT_MAX);
        repeat (120) send_draw(draw_value(TABLE_DEPTH, WEIGHT_MAX));

        total = rand_weight();
        set_table(2047, total);
        repeat (30) send_draw(draw_value(TABLE_DEPTH, total));

        set_table(0, '0);
        repeat (12) send_draw(draw_value(1, '0));

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase++;
            no_idle = (phase % 4 == 0);
            case ($urandom_range(0, 9))
                0: count = 1;
                1: count = $urandom_range(65, TABLE_DEPTH);
                2: count = $urandom_range(TABLE_DEPTH + 1, 2047);
                3: count = TABLE_DEPTH;
                default: count = $urandom_range(2, 48);
            endcase
            total = rand_total();
            set_table(count, total);
            used = clamp_count(count);
            if (used <= 64)
                load_sorted(used, total);
            if (phase == 3)
            begin
                long_hold_req = 1'b1;
                repeat (40) send_draw(draw_value(used, total));
            end
            else
            begin
                for (int k = 0; k < 40; k++)
                begin
                    if (phase == 5 && k == 20)
                        settle();
                    mixed_item(used, total);
                end
            end
        end
        no_idle = 1'b0;

        settle();
        $display("%0d transfers in: %0d loads, %0d draws, %0d of them out of range",
                 items_sent, board.loads, board.draws, board.misses);
        $display("%0d table settings, entry counts 0 to 2047, %0d cycles",
                 settings, cycle_count);
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wis_pkg.sv
rtl/wis_ram.sv
rtl/wis_datapath.sv
rtl/wis_ctrl.sv
rtl/weighted_index_sampler.sv
tb/sv/weighted_index_sampler_test.sv
